// ===== hdl/ifd_pkg.sv =====
// Package for the inertial sensor frame deframer.
// Holds frame constants, the byte and result types, and the checksum helper.
// No dependencies.
`timescale 1ns / 1ps

package ifd_pkg;

    localparam int FRAME_LEN = 11;
    localparam int SUM_LEN   = 10;

    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_FIRST  = 8'h51;
    localparam logic [7:0] TYPE_LAST   = 8'h54;

    typedef logic [7:0]         t_byte;
    typedef logic signed [15:0] t_word;

    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
        t_word      word_d;
        t_word      word_c;
        t_word      word_b;
        t_word      word_a;
    } t_frame;

    function automatic t_byte sum_bytes(input t_byte b [SUM_LEN]);
        t_byte s;
        s = '0;
        for (int k = 0; k < SUM_LEN; k++) begin
            s = s + b[k];
        end
        return s;
    endfunction

endpackage

// ===== hdl/ifd_cell.sv =====
// One window cell: holds a byte and its valid flag, takes its neighbour's on shift.
// Depends on ifd_pkg.
`timescale 1ns / 1ps

module ifd_cell
    import ifd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  logic  i_clear,
    input  t_byte i_byte,
    input  logic  i_valid,
    output t_byte o_byte,
    output logic  o_valid
);

    t_byte r_byte;
    logic  r_valid;
    logic  n_valid;

    always_comb begin
        if (i_shift) begin
            n_valid = i_valid && !i_clear;
        end else begin
            n_valid = r_valid && !i_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

// ===== hdl/ifd_check.sv =====
// Frame checker: header, type range and 8-bit sum over the first ten bytes.
// Depends on ifd_pkg.
`timescale 1ns / 1ps

module ifd_check
    import ifd_pkg::*;
(
    input  t_byte  i_win [FRAME_LEN],
    input  logic   i_full,
    output t_frame o_frame
);

    t_byte w_sum_in [SUM_LEN];
    t_byte w_kind;

    always_comb begin
        for (int k = 0; k < SUM_LEN; k++) begin
            w_sum_in[k] = i_win[k];
        end
    end

    assign w_kind = i_win[1] - TYPE_FIRST;

    always_comb begin
        o_frame.hit    = i_full
                      && (i_win[0] == HEADER_BYTE)
                      && (i_win[1] >= TYPE_FIRST)
                      && (i_win[1] <= TYPE_LAST)
                      && (sum_bytes(w_sum_in) == i_win[SUM_LEN]);
        o_frame.kind   = w_kind[1:0];
        o_frame.word_a = {i_win[3], i_win[2]};
        o_frame.word_b = {i_win[5], i_win[4]};
        o_frame.word_c = {i_win[7], i_win[6]};
        o_frame.word_d = {i_win[9], i_win[8]};
    end

endmodule

// ===== hdl/imu_frame_deframer_unit.sv =====
// Inertial sensor frame deframer, top level.
// Depends on ifd_pkg, ifd_cell and ifd_check.
//
// Usage:
//   s_axis carries the received serial stream, one byte per transfer in tdata.
//   m_axis carries one result per valid 11-byte frame: tuser holds the frame
//   kind (type byte minus 0x51), tdata the four signed little-endian words.
//   The window is a row of 11 cells; every input transfer shifts it by one.
//   A frame is found when the window is full, starts with 0x55, has a type of
//   0x51 to 0x54 and its last byte equals the 8-bit sum of the first ten.
//   The completing byte enters the window, then the result goes to m_axis
//   via the output register once it is free. Throughput: one byte per cycle
//   while s_axis_tready is high; a load empties the window but for a byte
//   taken in the same cycle. Reset empties the window and drops any pending
//   result. When the receiver stalls with a result held, s_axis_tready
//   falls only while a further finished frame waits for the output register.
`timescale 1ns / 1ps

module imu_frame_deframer_unit
    import ifd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] word_a, [31:16] word_b,
                                        // [47:32] word_c, [63:48] word_d
    output logic [1:0]  m_axis_tuser    // [1:0] frame_kind
);

    t_byte  w_byte [FRAME_LEN];
    logic   [FRAME_LEN-1:0] w_valid;
    t_frame w_frame;
    logic   w_can_load;
    logic   w_load;
    logic   w_shift;

    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [63:0] r_out_data;
    logic        n_out_valid;

    assign w_can_load    = !r_out_valid || m_axis_tready;
    assign w_load        = w_frame.hit && w_can_load;
    assign s_axis_tready = !w_frame.hit || w_can_load;
    assign w_shift       = s_axis_tvalid && s_axis_tready;

    for (genvar g = 0; g < FRAME_LEN; g++) begin : g_cell
        if (g == FRAME_LEN - 1) begin : g_tail
            ifd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_clear (w_load && !w_shift),
                .i_byte  (s_axis_tdata),
                .i_valid (1'b1),
                .o_byte  (w_byte[g]),
                .o_valid (w_valid[g])
            );
        end else begin : g_body
            ifd_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_clear (w_load),
                .i_byte  (w_byte[g+1]),
                .i_valid (w_valid[g+1]),
                .o_byte  (w_byte[g]),
                .o_valid (w_valid[g])
            );
        end
    end

    ifd_check u_check (
        .i_win   (w_byte),
        .i_full  (w_valid[0]),
        .o_frame (w_frame)
    );

    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // hold the result until the transfer completes
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_kind <= w_frame.kind;
            r_out_data <= {w_frame.word_d, w_frame.word_c, w_frame.word_b, w_frame.word_a};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== test/tb_top.sv =====
// Testbench for imu_frame_deframer_unit: feeds serial bytes as clean, broken and noisy frames.
// Predicts each decoded sample from its own sliding window and checks every m_axis transfer.
// Depends on ifd_pkg and the imu_frame_deframer_unit RTL.
`timescale 1ns / 1ps

module tb_top;
    import ifd_pkg::*;

    localparam int RX_ITEMS     = 750;
    localparam int BURST_MAX    = 16;
    localparam int GAP_MAX      = 5;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_NS     = 400_000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [1:0] kind;
        t_word      word_a;
        t_word      word_b;
        t_word      word_c;
        t_word      word_d;
    } t_sample;

    typedef enum int {FLAW_NONE, FLAW_HEADER, FLAW_TYPE, FLAW_SUM, FLAW_CUT} t_flaw;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // [15:0] word_a, [31:16] word_b,
                                       // [47:32] word_c, [63:48] word_d
    logic [1:0]  m_axis_tuser;         // [1:0] frame_kind

    imu_frame_deframer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    t_byte   rx_window [FRAME_LEN];
    int      rx_fill;
    t_sample pending_samples [$];
    int      err_count     = 0;
    int      rx_bytes_sent = 0;
    int      burst_left    = 0;
    bit      gaps_on       = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb_top: done, errors");
        $finish;
    end

    // Sliding-window deframer: append, or shift once full; emit and clear on a good frame.
    function automatic void deframe_byte(input t_byte b);
        t_byte   csum;
        t_sample s;
        if (rx_fill < FRAME_LEN) begin
            rx_window[rx_fill] = b;
            rx_fill++;
        end else begin
            for (int k = 0; k < FRAME_LEN - 1; k++) rx_window[k] = rx_window[k + 1];
            rx_window[FRAME_LEN - 1] = b;
        end
        if (rx_fill < FRAME_LEN) return;
        if (rx_window[0] != HEADER_BYTE) return;
        if (rx_window[1] < TYPE_FIRST || rx_window[1] > TYPE_LAST) return;
        csum = '0;
        for (int k = 0; k < SUM_LEN; k++) csum = csum + rx_window[k];
        if (csum != rx_window[SUM_LEN]) return;
        s.kind   = 2'(rx_window[1] - TYPE_FIRST);
        s.word_a = {rx_window[3], rx_window[2]};
        s.word_b = {rx_window[5], rx_window[4]};
        s.word_c = {rx_window[7], rx_window[6]};
        s.word_d = {rx_window[9], rx_window[8]};
        pending_samples.push_back(s);
        for (int k = 0; k < FRAME_LEN; k++) rx_window[k] = '0;
        rx_fill = 0;
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return t_word'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Receiver stall pattern: switch mode every so often.
    t_stall      stall_mode = STALL_NONE;
    int          mode_left  = 0;
    logic [31:0] stall_tick = '0;

    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (mode_left == 0) begin
            stall_mode <= t_stall'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  m_axis_tready <= 1'b1;
            STALL_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:     m_axis_tready <= (stall_tick[2:0] < 3'd3);
        endcase
    end

    always @(posedge i_clk) begin : check_sample
        t_sample want;
        t_sample got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind   = m_axis_tuser;
            got.word_a = m_axis_tdata[15:0];
            got.word_b = m_axis_tdata[31:16];
            got.word_c = m_axis_tdata[47:32];
            got.word_d = m_axis_tdata[63:48];
            if (pending_samples.size() == 0) begin
                err_count++;
                if (err_count <= REPORT_MAX)
                    $display("%0t: unexpected sample kind %0d words %0d %0d %0d %0d", $realtime,
                             got.kind, got.word_a, got.word_b, got.word_c, got.word_d);
            end else begin
                want = pending_samples.pop_front();
                if (want.kind !== got.kind || want.word_a !== got.word_a ||
                    want.word_b !== got.word_b || want.word_c !== got.word_c ||
                    want.word_d !== got.word_d) begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display({"%0t: sample mismatch exp kind %0d %0d %0d %0d %0d,",
                                  " got %0d %0d %0d %0d %0d"},
                                 $realtime, want.kind, want.word_a, want.word_b, want.word_c,
                                 want.word_d, got.kind, got.word_a, got.word_b, got.word_c,
                                 got.word_d);
                end
            end
        end
    end

    // Send one byte; called at a rising edge, returns at the edge of its transfer.
    task automatic send_byte(input t_byte b);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, BURST_MAX);
            gap        = $urandom_range(0, GAP_MAX);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        rx_bytes_sent++;
        deframe_byte(b);
    endtask

    task automatic send_frame(input t_byte type_b, input t_word wa, input t_word wb,
                              input t_word wc, input t_word wd, input t_flaw flaw);
        t_byte f [FRAME_LEN];
        int    n;
        n    = FRAME_LEN;
        f[0] = HEADER_BYTE;
        f[1] = type_b;
        f[2] = wa[7:0];
        f[3] = wa[15:8];
        f[4] = wb[7:0];
        f[5] = wb[15:8];
        f[6] = wc[7:0];
        f[7] = wc[15:8];
        f[8] = wd[7:0];
        f[9] = wd[15:8];
        case (flaw)
            FLAW_HEADER: f[0] = f[0] ^ 8'($urandom_range(1, 255));
            FLAW_TYPE:   f[1] = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h50))
                                                     : 8'($urandom_range(8'h55, 8'hFF));
            FLAW_CUT:    n = $urandom_range(1, FRAME_LEN - 1);
            default:     ;
        endcase
        f[SUM_LEN] = '0;
        for (int k = 0; k < SUM_LEN; k++) f[SUM_LEN] = f[SUM_LEN] + f[k];
        if (flaw == FLAW_SUM) f[SUM_LEN] = f[SUM_LEN] ^ 8'($urandom_range(1, 255));
        for (int k = 0; k < n; k++) send_byte(f[k]);
    endtask

    task automatic test_frame_extremes();
        gaps_on = 1'b0;
        send_frame(TYPE_FIRST, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, FLAW_NONE);
        send_frame(TYPE_LAST, 16'sh7FFF, 16'sh8000, 16'shFFFF, 16'sh0000, FLAW_NONE);
        send_frame(TYPE_FIRST + 8'd1, 16'sh0001, 16'shFFFE, 16'sh5555, 16'shAAAA, FLAW_NONE);
    endtask

    task automatic test_rejected_frames();
        gaps_on = 1'b1;
        send_frame(TYPE_FIRST, 16'sh1234, 16'sh0000, 16'sh0000, 16'sh0000, FLAW_SUM);
        send_frame(8'h50, 16'sh0102, 16'sh0304, 16'sh0506, 16'sh0708, FLAW_NONE);
        send_frame(8'h55, 16'sh0102, 16'sh0304, 16'sh0506, 16'sh0708, FLAW_NONE);
        send_byte(HEADER_BYTE);
        send_frame(TYPE_FIRST + 8'd2, 16'sh7F80, 16'sh807F, 16'sh00FF, 16'shFF00, FLAW_NONE);
    endtask

    task automatic test_random_stream();
        int n;
        while (rx_bytes_sent < RX_ITEMS) begin
            if ($urandom_range(0, 15) == 0) gaps_on = ~gaps_on;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    send_frame(8'($urandom_range(TYPE_FIRST, TYPE_LAST)), pick_word(),
                               pick_word(), pick_word(), pick_word(), FLAW_NONE);
                6: begin
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        case ($urandom_range(0, 3))
                            0:       send_byte(HEADER_BYTE);
                            1:       send_byte(8'($urandom_range(TYPE_FIRST, TYPE_LAST)));
                            default: send_byte(8'($urandom_range(0, 255)));
                        endcase
                    end
                end
                default:
                    send_frame(8'($urandom_range(TYPE_FIRST, TYPE_LAST)), pick_word(),
                               pick_word(), pick_word(), pick_word(),
                               t_flaw'($urandom_range(FLAW_HEADER, FLAW_CUT)));
            endcase
        end
    endtask

    initial begin
        for (int k = 0; k < FRAME_LEN; k++) rx_window[k] = '0;
        rx_fill = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_frame_extremes();
        test_rejected_frames();
        test_random_stream();

        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_samples.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
